### rtl/double_ended_queue_top_defines.svh
// Assertion macros used by the deque controller.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Checked at every edge outside reset.
`define DQE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define DQE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/dqe_pkg.sv
`default_nettype none

package dqe_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_INVERT     = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] data_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data_out;
      logic [6:0]  count;
   } rsp_type;

   // response bookkeeping registered while the ram read completes
   typedef struct packed {
      logic       valid;
      logic       rd_sel;
      status_type status;
      logic [6:0] count;
   } meta_type;

endpackage

`default_nettype wire

### rtl/dqe_ram.sv
`default_nettype none

module dqe_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic             re,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/dqe_ctrl.sv
`default_nettype none

`include "double_ended_queue_top_defines.svh"

module dqe_ctrl
   import dqe_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_item,
   output logic                  mem_we,
   output logic                  mem_re,
   output logic      [AW-1:0]    mem_addr,
   output logic      [WIDTH-1:0] mem_wdata,
   output meta_type              meta
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rev_ff, rev_in;
   logic          busy_ff;
   meta_type      meta_ff, meta_in;

   logic          accept;
   logic          at_high;
   logic          is_full, is_empty;
   logic [SW-1:0] sum, sum_m1, inc, push_raw, high_raw, inc_raw;
   logic [AW-1:0] push_slot, high_slot, inc_head, dec_head;
   logic [63:0]   din_wide, cnt_wide;
   status_type    status;
   logic          rd_sel;

   assign accept   = start && !busy_ff;
   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);

   assign sum      = SW'(head_ff) + SW'(count_ff);
   assign sum_m1   = sum - SW'(1);
   assign inc      = SW'(head_ff) + SW'(1);
   assign push_raw = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
   assign high_raw = (sum_m1 >= SW'(DEPTH)) ? sum_m1 - SW'(DEPTH) : sum_m1;
   assign inc_raw  = (inc >= SW'(DEPTH)) ? inc - SW'(DEPTH) : inc;
   assign push_slot = push_raw[AW-1:0];
   assign high_slot = high_raw[AW-1:0];
   assign inc_head  = inc_raw[AW-1:0];
   assign dec_head  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);

   assign din_wide  = 64'(req_item.data_in);
   assign mem_wdata = din_wide[WIDTH-1:0];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      rev_in   = rev_ff;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_addr = head_ff;
      status   = ST_OK;
      rd_sel   = 1'b0;
      at_high  = 1'b0;
      case (op_type'(req_item.op))
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            at_high = (op_type'(req_item.op) == OP_PUSH_BACK) ^ rev_ff;
            if (is_full) begin
               status = ST_FULL;
            end else begin
               mem_we   = accept;
               count_in = count_ff + CW'(1);
               if (at_high) begin
                  mem_addr = push_slot;
               end else begin
                  mem_addr = dec_head;
                  head_in  = dec_head;
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            at_high = req_item.op[0] ^ rev_ff;
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               mem_re   = accept;
               rd_sel   = 1'b1;
               mem_addr = at_high ? high_slot : head_ff;
               if (op_type'(req_item.op) == OP_POP_FRONT ||
                   op_type'(req_item.op) == OP_POP_BACK) begin
                  count_in = count_ff - CW'(1);
                  if (!at_high) begin
                     head_in = inc_head;
                  end
               end
            end
         end
         OP_INVERT: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               rev_in = !rev_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign cnt_wide = 64'(count_in);

   always_comb begin
      meta_in.valid  = accept;
      meta_in.rd_sel = rd_sel;
      meta_in.status = status;
      meta_in.count  = cnt_wide[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
         busy_ff  <= 1'b1;
         meta_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         meta_ff <= meta_in;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
            rev_ff   <= rev_in;
         end
      end
   end

   assign busy = busy_ff;
   assign meta = meta_ff;

   `DQE_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "occupancy above depth")
   `DQE_ASSERT(a_rsp_follows_req, meta_ff.valid == $past(start && !busy_ff), "response not one cycle after request")
   `DQE_ASSERT(a_full_only_when_full, (meta_ff.valid && meta_ff.status == ST_FULL) |-> (count_ff == CW'(DEPTH) && $past(mem_we) == 1'b0), "full status with room left")
   `DQE_ASSERT(a_empty_keeps_zero, (meta_ff.valid && meta_ff.status == ST_EMPTY) |-> (count_ff == '0 && !meta_ff.rd_sel), "empty status with data")
   `DQE_ASSERT_ALWAYS(a_one_access, !(mem_we && mem_re), "read and write in one cycle")

endmodule

`default_nettype wire

### rtl/double_ended_queue_top.sv
//  channel   ports                          handshake
//  request   start, busy, req_item          taken when start && !busy
//  response  rsp_strobe, rsp_item           valid for the one strobe cycle
//
//  One request per cycle while busy is low; its response appears on the next cycle.
//  The single ram port sets the rate: at most one read or one write per request.
//  busy is high only during reset and the cycle after it.
//  Reset is synchronous and clears pointers, count and direction; ram is not cleared.
//  The receiver cannot stall; every response is shown exactly once.
`default_nettype none

module double_ended_queue_top
   import dqe_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   localparam int AW = $clog2(DEPTH);

   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_addr;
   logic [WIDTH-1:0] mem_wdata, mem_rdata;
   logic [63:0]      rdata_wide;
   meta_type         meta;

   dqe_ctrl #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH),
      .AW    (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .meta      (meta)
   );

   dqe_ram #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rdata_wide = 64'(mem_rdata);

   always_comb begin
      rsp_strobe        = meta.valid;
      rsp_item.status   = meta.status;
      rsp_item.count    = meta.count;
      rsp_item.data_out = meta.rd_sel ? rdata_wide[31:0] : 32'd0;
   end

endmodule

`default_nettype wire
